### src/assert_macros.svh
// Concurrent assertion helpers, empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SMLAT_ASSERT(label, prop, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define SMLAT_ASSERT_ALWAYS(label, prop, clk) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define SMLAT_ASSERT(label, prop, clk, rst_n)

`define SMLAT_ASSERT_ALWAYS(label, prop, clk)

`endif

`endif

### src/smlat_pkg.sv
package smlat_pkg;

  localparam int unsigned NumModifiersDefault = 8;
  localparam int unsigned KeyIdxW    = 3;
  localparam int unsigned KindW      = 3;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned ThreshW    = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned MaskW      = 8;
  localparam int unsigned AnnW       = 2;

  typedef enum logic [KindW-1:0] {
    EvRawPress   = 3'd0,
    EvRawRelease = 3'd1,
    EvPress      = 3'd2,
    EvRelease    = 3'd3,
    EvTap        = 3'd4
  } event_kind_e;

  typedef enum logic [ModeW-1:0] {
    ModeMomentary = 2'd0,
    ModeLatch     = 2'd1,
    ModeHybrid    = 2'd2
  } key_mode_e;

  typedef enum logic [AnnW-1:0] {
    AnnNone   = 2'd0,
    AnnLock   = 2'd1,
    AnnUnlock = 2'd2
  } announce_e;

  typedef struct packed {
    logic             engaged;
    logic             locked;
    logic [TimeW-1:0] stamp;
  } key_state_t;

  typedef struct packed {
    logic               valid;
    logic [KeyIdxW-1:0] idx;
    key_state_t         state;
  } key_write_t;

endpackage

### src/smlat_if.sv
interface smlat_req_if;
  import smlat_pkg::*;

  logic               valid;
  logic               ready;
  logic [KeyIdxW-1:0] modifier_index;
  logic [KindW-1:0]   event_kind;
  logic [ModeW-1:0]   key_mode;
  logic [ThreshW-1:0] hold_threshold_ms;
  logic [TimeW-1:0]   now_ms;

  modport source (
    output valid, modifier_index, event_kind, key_mode, hold_threshold_ms, now_ms,
    input  ready
  );

  modport sink (
    input  valid, modifier_index, event_kind, key_mode, hold_threshold_ms, now_ms,
    output ready
  );
endinterface

interface smlat_rsp_if;
  import smlat_pkg::*;

  logic             valid;
  logic             ready;
  logic [MaskW-1:0] engaged_mask;
  logic [MaskW-1:0] locked_mask;
  logic [AnnW-1:0]  announce;

  modport source (
    output valid, engaged_mask, locked_mask, announce,
    input  ready
  );

  modport sink (
    input  valid, engaged_mask, locked_mask, announce,
    output ready
  );
endinterface

### src/sticky_modifier_latch_core.sv
// Channel  Dir  Fields                                                    Accept
// req_i    in   modifier_index event_kind key_mode hold_threshold_ms now_ms  valid & ready
// rsp_o    out  engaged_mask locked_mask announce                         valid & ready
//
// One request per cycle sustained while rsp_o is not stalled; each result is registered.
// Input register -> one rule pass and flag/stamp update -> result register.
// Flags and stamps reset to zero on rst_ni low.
// A stalled result holds; the input register still takes a request while empty.
module sticky_modifier_latch_core
  import smlat_pkg::*;
#(
  parameter int unsigned NumModifiers = NumModifiersDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smlat_req_if.sink   req_i,
  smlat_rsp_if.source rsp_o
);

  `include "assert_macros.svh"

  logic               in_valid_q;
  logic [KeyIdxW-1:0] idx_q;
  logic [KindW-1:0]   kind_q;
  logic [ModeW-1:0]   mode_q;
  logic [ThreshW-1:0] thresh_q;
  logic [TimeW-1:0]   now_q;

  logic             rsp_valid_q;
  logic [MaskW-1:0] eng_mask_q, eng_mask_d;
  logic [MaskW-1:0] lck_mask_q, lck_mask_d;
  announce_e        ann_q, ann_d;

  logic       advance;
  logic       in_range;
  key_state_t cur_state, nxt_state;
  key_write_t key_wr;

  assign advance     = in_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign in_range    = 32'(idx_q) < NumModifiers;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      idx_q    <= req_i.modifier_index;
      kind_q   <= req_i.event_kind;
      mode_q   <= req_i.key_mode;
      thresh_q <= req_i.hold_threshold_ms;
      now_q    <= req_i.now_ms;
    end
  end

  smlat_rule u_rule (
    .kind_i     (kind_q),
    .mode_i     (mode_q),
    .thresh_i   (thresh_q),
    .now_i      (now_q),
    .cur_i      (cur_state),
    .nxt_o      (nxt_state),
    .announce_o (ann_d)
  );

  assign key_wr.valid = advance && in_range;
  assign key_wr.idx   = idx_q;
  assign key_wr.state = nxt_state;

  smlat_store #(
    .NumModifiers (NumModifiers)
  ) u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rd_idx_i       (idx_q),
    .rd_state_o     (cur_state),
    .wr_i           (key_wr),
    .engaged_mask_o (eng_mask_d),
    .locked_mask_o  (lck_mask_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      eng_mask_q <= eng_mask_d;
      lck_mask_q <= lck_mask_d;
      ann_q      <= in_range ? ann_d : AnnNone;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.engaged_mask = eng_mask_q;
  assign rsp_o.locked_mask  = lck_mask_q;
  assign rsp_o.announce     = ann_q;

  `SMLAT_ASSERT(a_advance_fills_rsp, advance |=> rsp_valid_q, clk_i, rst_ni)
  `SMLAT_ASSERT(a_stall_holds_req, in_valid_q && !advance |=> in_valid_q, clk_i, rst_ni)
  `SMLAT_ASSERT(a_lock_sets_mask, advance && in_range && ann_d == AnnLock |=> lck_mask_q != '0, clk_i, rst_ni)
  `SMLAT_ASSERT(a_no_write_when_idle, !in_valid_q |-> !key_wr.valid, clk_i, rst_ni)

endmodule

### src/smlat_rule.sv
module smlat_rule
  import smlat_pkg::*;
(
  input  logic [KindW-1:0]   kind_i,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [ThreshW-1:0] thresh_i,
  input  logic [TimeW-1:0]   now_i,
  input  key_state_t         cur_i,
  output key_state_t         nxt_o,
  output announce_e          announce_o
);

  logic [TimeW-1:0] held;
  logic             long_hold;

  assign held      = now_i - cur_i.stamp;
  assign long_hold = held >= {{(TimeW-ThreshW){1'b0}}, thresh_i};

  always_comb begin
    nxt_o      = cur_i;
    announce_o = AnnNone;
    unique case (event_kind_e'(kind_i))
      EvRawPress: begin
        if (!cur_i.engaged) begin
          nxt_o.engaged = 1'b1;
          nxt_o.stamp   = now_i;
        end else begin
          nxt_o.stamp = '0;
        end
      end
      EvRawRelease: begin
        if (long_hold) begin
          if (cur_i.locked) begin
            nxt_o.locked = 1'b0;
            announce_o   = AnnUnlock;
          end
          nxt_o.engaged = 1'b0;
        end else begin
          nxt_o.locked = 1'b1;
          announce_o   = AnnLock;
        end
        nxt_o.stamp = '0;
      end
      EvPress, EvRelease, EvTap: begin
        unique case (key_mode_e'(mode_i))
          ModeMomentary: begin
            nxt_o.engaged = event_kind_e'(kind_i) == EvPress;
            nxt_o.locked  = 1'b0;
            nxt_o.stamp   = (event_kind_e'(kind_i) == EvPress) ? now_i : '0;
          end
          ModeLatch: begin
            if (event_kind_e'(kind_i) == EvTap) begin
              nxt_o.engaged = !cur_i.engaged;
              nxt_o.locked  = !cur_i.engaged;
              nxt_o.stamp   = '0;
            end
          end
          ModeHybrid: begin
            if (event_kind_e'(kind_i) == EvPress) begin
              if (!cur_i.locked) nxt_o.engaged = 1'b1;
            end else if (event_kind_e'(kind_i) == EvTap) begin
              nxt_o.locked  = !cur_i.locked;
              nxt_o.engaged = !cur_i.locked;
            end else begin
              nxt_o.locked  = 1'b0;
              nxt_o.engaged = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

### src/smlat_store.sv
module smlat_store
  import smlat_pkg::*;
#(
  parameter int unsigned NumModifiers = NumModifiersDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [KeyIdxW-1:0] rd_idx_i,
  output key_state_t         rd_state_o,
  input  key_write_t         wr_i,
  output logic [MaskW-1:0]   engaged_mask_o,
  output logic [MaskW-1:0]   locked_mask_o
);

  logic [NumModifiers-1:0] eng_q, eng_d;
  logic [NumModifiers-1:0] lck_q, lck_d;
  logic [TimeW-1:0]        stamp_q [NumModifiers];
  logic [TimeW-1:0]        stamp_d [NumModifiers];

  always_comb begin
    rd_state_o = '0;
    for (int unsigned i = 0; i < NumModifiers; i++) begin
      if (32'(rd_idx_i) == i) begin
        rd_state_o.engaged = eng_q[i];
        rd_state_o.locked  = lck_q[i];
        rd_state_o.stamp   = stamp_q[i];
      end
    end
  end

  for (genvar i = 0; i < NumModifiers; i++) begin : g_key
    localparam int unsigned Slot = i;
    logic hit;

    assign hit        = wr_i.valid && (32'(wr_i.idx) == Slot);
    assign eng_d[i]   = hit ? wr_i.state.engaged : eng_q[i];
    assign lck_d[i]   = hit ? wr_i.state.locked  : lck_q[i];
    assign stamp_d[i] = hit ? wr_i.state.stamp   : stamp_q[i];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        eng_q[i]   <= 1'b0;
        lck_q[i]   <= 1'b0;
        stamp_q[i] <= '0;
      end else begin
        eng_q[i]   <= eng_d[i];
        lck_q[i]   <= lck_d[i];
        stamp_q[i] <= stamp_d[i];
      end
    end
  end

  for (genvar b = 0; b < MaskW; b++) begin : g_mask
    if (b < NumModifiers) begin : g_live
      assign engaged_mask_o[b] = eng_d[b];
      assign locked_mask_o[b]  = lck_d[b];
    end else begin : g_none
      assign engaged_mask_o[b] = 1'b0;
      assign locked_mask_o[b]  = 1'b0;
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import smlat_pkg::*;

  localparam int unsigned NumKeys = NumModifiersDefault;
  localparam logic [KindW-1:0] KindReservedLo = 3'd5;
  localparam logic [KindW-1:0] KindReservedMid = 3'd6;
  localparam logic [KindW-1:0] KindReservedHi = 3'd7;
  localparam logic [ModeW-1:0] ModeReserved = 2'd3;
  localparam int unsigned MaxGap = 13;
  localparam int unsigned RandomEvents = 600;
  localparam int unsigned HoldOffLen = 120;

  typedef struct packed {
    logic [KeyIdxW-1:0] idx;
    logic [KindW-1:0]   kind;
    logic [ModeW-1:0]   mode;
    logic [ThreshW-1:0] thresh;
    logic [TimeW-1:0]   now;
  } key_event_t;

  typedef struct packed {
    logic [MaskW-1:0] engaged_mask;
    logic [MaskW-1:0] locked_mask;
    logic [AnnW-1:0]  announce;
  } key_masks_t;

  logic clk_i;
  logic rst_ni;

  smlat_req_if req_if ();
  smlat_rsp_if rsp_if ();

  sticky_modifier_latch_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  logic             key_engaged [NumKeys];
  logic             key_locked  [NumKeys];
  logic [TimeW-1:0] key_stamp   [NumKeys];

  key_masks_t       pending_masks [$];
  int unsigned      fail_count;
  int unsigned      events_sent;
  bit               send_idle;
  bit               recv_idle;
  int unsigned      hold_off_cycles;
  logic [TimeW-1:0] clock_ms;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic key_masks_t apply_key_event(input key_event_t ev);
    key_masks_t       res;
    logic [TimeW-1:0] held;
    int unsigned      k;
    k = ev.idx;
    res = '0;
    res.announce = AnnNone;
    if (k < NumKeys && ev.kind <= EvTap) begin
      if (ev.kind == EvRawPress) begin
        if (!key_engaged[k]) begin
          key_engaged[k] = 1'b1;
          key_stamp[k] = ev.now;
        end else begin
          key_stamp[k] = '0;
        end
      end else if (ev.kind == EvRawRelease) begin
        held = ev.now - key_stamp[k];
        if (held >= TimeW'(ev.thresh)) begin
          if (key_locked[k]) begin
            key_locked[k] = 1'b0;
            res.announce = AnnUnlock;
          end
          key_engaged[k] = 1'b0;
        end else begin
          key_locked[k] = 1'b1;
          res.announce = AnnLock;
        end
        key_stamp[k] = '0;
      end else if (ev.mode == ModeMomentary) begin
        key_engaged[k] = (ev.kind == EvPress);
        key_locked[k] = 1'b0;
        key_stamp[k] = key_engaged[k] ? ev.now : '0;
      end else if (ev.mode == ModeLatch) begin
        if (ev.kind == EvTap) begin
          key_engaged[k] = !key_engaged[k];
          key_locked[k] = key_engaged[k];
          key_stamp[k] = '0;
        end
      end else if (ev.mode == ModeHybrid) begin
        if (ev.kind == EvPress) begin
          if (!key_locked[k]) key_engaged[k] = 1'b1;
        end else if (ev.kind == EvTap) begin
          key_locked[k] = !key_locked[k];
          key_engaged[k] = key_locked[k];
        end else begin
          key_locked[k] = 1'b0;
          key_engaged[k] = 1'b0;
        end
      end
    end
    for (int i = 0; i < NumKeys && i < MaskW; i++) begin
      res.engaged_mask[i] = key_engaged[i];
      res.locked_mask[i] = key_locked[i];
    end
    return res;
  endfunction

  task automatic send_key_event(input logic [KeyIdxW-1:0] idx, input logic [KindW-1:0] kind,
                                input logic [ModeW-1:0] mode, input logic [ThreshW-1:0] thresh,
                                input logic [TimeW-1:0] now);
    key_event_t  ev;
    int unsigned gap;
    ev = '{idx: idx, kind: kind, mode: mode, thresh: thresh, now: now};
    gap = send_idle ? $urandom_range(0, MaxGap) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.modifier_index = ev.idx;
    req_if.event_kind = ev.kind;
    req_if.key_mode = ev.mode;
    req_if.hold_threshold_ms = ev.thresh;
    req_if.now_ms = ev.now;
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    pending_masks.insert(pending_masks.size(), apply_key_event(ev));
    events_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    wait (pending_masks.size() == 0);
  endtask

  task automatic send_raw_hold(input logic [KeyIdxW-1:0] idx);
    logic [ThreshW-1:0] thresh;
    logic [TimeW-1:0]   held;
    clock_ms += $urandom_range(1, 3000);
    send_key_event(idx, EvRawPress, ModeW'($urandom_range(0, 2**ModeW - 1)),
                   ThreshW'($urandom), clock_ms);
    if ($urandom_range(0, 3) == 0)
      send_key_event(idx, EvRawPress, ModeW'($urandom_range(0, 2**ModeW - 1)),
                     ThreshW'($urandom), clock_ms + $urandom_range(0, 50));
    thresh = ThreshW'($urandom_range(0, 2**ThreshW - 1));
    case ($urandom_range(0, 3))
      0: held = (thresh == 0) ? '0 : TimeW'(thresh) - 1;
      1: held = TimeW'(thresh);
      2: held = $urandom_range(0, thresh);
      default: held = TimeW'(thresh) + $urandom_range(0, 70000);
    endcase
    clock_ms += held;
    send_key_event(idx, EvRawRelease, ModeW'($urandom_range(0, 2**ModeW - 1)), thresh,
                   clock_ms);
  endtask

  task automatic send_random_event();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: send_raw_hold(KeyIdxW'($urandom_range(0, NumKeys - 1)));
      6, 7, 8: begin
        clock_ms += $urandom_range(0, 2000);
        send_key_event(KeyIdxW'($urandom_range(0, NumKeys - 1)),
                       KindW'($urandom_range(EvPress, EvTap)),
                       ModeW'($urandom_range(ModeMomentary, ModeHybrid)),
                       ThreshW'($urandom), clock_ms);
      end
      default: begin
        if ($urandom_range(0, 3) == 0) clock_ms = {16'hFFFF, 16'($urandom)};
        send_key_event(KeyIdxW'($urandom_range(0, 2**KeyIdxW - 1)),
                       KindW'($urandom_range(0, 2**KindW - 1)),
                       ModeW'($urandom_range(0, 2**ModeW - 1)), ThreshW'($urandom),
                       $urandom);
      end
    endcase
  endtask

  task automatic test_raw_timing();
    send_key_event(0, EvRawRelease, ModeMomentary, 16'd0, 32'd0);
    send_key_event(7, EvRawPress, ModeMomentary, 16'd100, 32'hFFFF_FFF0);
    send_key_event(7, EvRawRelease, ModeMomentary, 16'd100, 32'h0000_0005);
    send_key_event(7, EvRawRelease, ModeLatch, 16'd100, 32'h0000_0005);
    send_key_event(7, EvRawPress, ModeReserved, 16'hFFFF, 32'd1000);
    send_key_event(7, EvRawRelease, ModeHybrid, 16'hFFFF, 32'hFFFF_FFFF);
    send_key_event(3, EvRawPress, ModeLatch, 16'd300, 32'd500);
    send_key_event(3, EvRawRelease, ModeLatch, 16'd300, 32'd800);
    send_key_event(3, EvRawPress, ModeMomentary, 16'd0, 32'd800);
    send_key_event(3, EvRawRelease, ModeMomentary, 16'hFFFF, 32'd800 + 32'd65534);
    send_key_event(3, EvRawPress, ModeMomentary, 16'd0, 32'd1);
    send_key_event(3, EvRawRelease, ModeMomentary, 16'hFFFF, 32'h0000_FFFF);
  endtask

  task automatic test_cooked_modes();
    send_key_event(1, EvPress, ModeMomentary, 16'd0, 32'd1234);
    send_key_event(1, EvTap, ModeMomentary, 16'd0, 32'd1300);
    send_key_event(1, EvPress, ModeMomentary, 16'd0, 32'hDEAD_BEEF);
    send_key_event(1, EvRelease, ModeMomentary, 16'd0, 32'd1400);
    send_key_event(2, EvTap, ModeLatch, 16'd0, 32'd1500);
    send_key_event(2, EvPress, ModeLatch, 16'd0, 32'd1600);
    send_key_event(2, EvRelease, ModeLatch, 16'd0, 32'd1700);
    send_key_event(2, EvTap, ModeLatch, 16'd0, 32'd1800);
    send_key_event(4, EvPress, ModeHybrid, 16'd0, 32'd1900);
    send_key_event(4, EvTap, ModeHybrid, 16'd0, 32'd2000);
    send_key_event(4, EvPress, ModeHybrid, 16'd0, 32'd2100);
    send_key_event(4, EvTap, ModeHybrid, 16'd0, 32'd2200);
    send_key_event(4, EvPress, ModeHybrid, 16'd0, 32'd2300);
    send_key_event(4, EvRelease, ModeHybrid, 16'd0, 32'd2400);
  endtask

  task automatic test_reserved_codes();
    send_key_event(5, EvPress, ModeReserved, 16'd0, 32'd2500);
    send_key_event(5, EvTap, ModeReserved, 16'd0, 32'd2600);
    send_key_event(6, EvRawPress, ModeMomentary, 16'd10, 32'd2700);
    send_key_event(6, KindReservedLo, ModeLatch, 16'd10, 32'd2800);
    send_key_event(6, KindReservedMid, ModeHybrid, 16'd10, 32'd2900);
    send_key_event(6, KindReservedHi, ModeMomentary, 16'd10, 32'd3000);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned start;
    start = events_sent;
    clock_ms = $urandom;
    while (events_sent - start < count) begin
      if ($urandom_range(0, 40) == 0) begin
        send_idle = 1'($urandom_range(0, 1));
        recv_idle = 1'($urandom_range(0, 1));
      end
      send_random_event();
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_off_cycles = HoldOffLen;
    repeat (40) send_random_event();
    wait_for_results();
  endtask

  task automatic test_drain_pause();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (15) send_random_event();
    wait_for_results();
    repeat (15) send_random_event();
    wait_for_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.modifier_index = '0;
    req_if.event_kind = EvRawPress;
    req_if.key_mode = ModeMomentary;
    req_if.hold_threshold_ms = '0;
    req_if.now_ms = '0;
    fail_count = 0;
    events_sent = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_off_cycles = 0;
    clock_ms = '0;
    for (int i = 0; i < NumKeys; i++) begin
      key_engaged[i] = 1'b0;
      key_locked[i] = 1'b0;
      key_stamp[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_raw_timing();
    test_cooked_modes();
    test_reserved_codes();
    wait_for_results();
    test_backpressure();
    test_drain_pause();
    test_random_traffic(RandomEvents);

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_masks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      gap = recv_idle ? $urandom_range(0, MaxGap) : 0;
      if (hold_off_cycles > 0) begin
        gap = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (gap > 0) begin
        rsp_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  always @(posedge clk_i) begin : check_results
    key_masks_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_masks.size() == 0) begin
        $error("unexpected result: engaged_mask %02h locked_mask %02h announce %0d",
               rsp_if.engaged_mask, rsp_if.locked_mask, rsp_if.announce);
        fail_count++;
      end else begin
        want = pending_masks.pop_front();
        if (rsp_if.engaged_mask !== want.engaged_mask) begin
          $error("engaged_mask: expected %02h, got %02h", want.engaged_mask,
                 rsp_if.engaged_mask);
          fail_count++;
        end
        if (rsp_if.locked_mask !== want.locked_mask) begin
          $error("locked_mask: expected %02h, got %02h", want.locked_mask,
                 rsp_if.locked_mask);
          fail_count++;
        end
        if (rsp_if.announce !== want.announce) begin
          $error("announce: expected %0d, got %0d", want.announce, rsp_if.announce);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### sticky_modifier_latch_core.f
+incdir+src
src/smlat_pkg.sv
src/smlat_if.sv
src/smlat_rule.sv
src/smlat_store.sv
src/sticky_modifier_latch_core.sv
verif/tb.sv
